### rtl/cpsd_pkg.sv
`timescale 1ns / 1ps
package cpsd_pkg;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_TICK   = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic REG_FAST_TIMEOUT = 1'b0;
  localparam logic REG_SLOW_TIMEOUT = 1'b1;

  localparam logic [7:0] FAST_TIMEOUT_RST = 8'd10;
  localparam logic [7:0] SLOW_TIMEOUT_RST = 8'd30;

  // Parameter groups
  localparam logic [15:0] PGN_DIST     = 16'hFEC1;
  localparam logic [15:0] PGN_FUEL     = 16'hFEE9;
  localparam logic [15:0] PGN_TACH     = 16'hFE6C;
  localparam logic [15:0] PGN_WHEEL    = 16'hFEF1;
  localparam logic [15:0] PGN_IGNORED  = 16'hF000;
  localparam logic [15:0] PGN_BRAKE    = 16'hF001;
  localparam logic [15:0] PGN_ACCEL    = 16'hF003;
  localparam logic [15:0] PGN_RPM      = 16'hF004;

  localparam logic [15:0] STALE_16 = 16'hFFFF;
  localparam logic [31:0] STALE_32 = 32'hFFFF_FFFF;

  // Age counter slots
  localparam int unsigned NumAge    = 7;
  localparam int unsigned AGE_TACH  = 0;
  localparam int unsigned AGE_WHEEL = 1;
  localparam int unsigned AGE_RPM   = 2;
  localparam int unsigned AGE_BRAKE = 3;
  localparam int unsigned AGE_ACCEL = 4;
  localparam int unsigned AGE_DIST  = 5;
  localparam int unsigned AGE_FUEL  = 6;

  typedef struct packed {
    logic [1:0]  op;
    logic [28:0] ext_id;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    logic        unknown_pgn;
    logic [7:0]  speed;
    logic [7:0]  direction;
    logic [15:0] rpm;
    logic [7:0]  brake;
    logic [7:0]  accel;
    logic [31:0] trip_distance;
    logic [31:0] total_distance;
    logic [31:0] trip_fuel;
    logic [31:0] total_fuel;
    logic [7:0]  sequence_res;
  } out_item_t;

endpackage

### rtl/cpsd_in_stage.sv
`timescale 1ns / 1ps
module cpsd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cpsd_pkg::in_item_t in_data_i,
  output logic               item_valid_o,
  output cpsd_pkg::in_item_t item_o,
  input  logic               item_ready_i
);
  import cpsd_pkg::*;

  logic     valid_q;
  in_item_t data_q;

  // hold the item until the decode stage takes it
  assign in_stall_o   = valid_q && !item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

### rtl/cpsd_decode.sv
`timescale 1ns / 1ps
module cpsd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                item_valid_i,
  input  cpsd_pkg::in_item_t  item_i,
  input  logic                adv_i,
  output cpsd_pkg::out_item_t snap_o
);
  import cpsd_pkg::*;

  logic [7:0]  fast_to_q, slow_to_q;
  logic [1:0]  spd_valid_q, spd_valid_d;
  logic [7:0]  tach_q, tach_d;
  logic [7:0]  wheel_q, wheel_d;
  logic [7:0]  dir_q, dir_d;
  logic [15:0] rpm_q, rpm_d;
  logic [7:0]  brake_q, brake_d;
  logic [7:0]  accel_q, accel_d;
  logic [31:0] dist_q [2];
  logic [31:0] dist_d [2];
  logic [31:0] fuel_q [2];
  logic [31:0] fuel_d [2];
  logic [7:0]  age_q [NumAge];
  logic [7:0]  age_d [NumAge];
  logic [7:0]  age_inc [NumAge];
  logic [7:0]  age_lim [NumAge];
  logic [NumAge-1:0] expired;
  logic [7:0]  report_q, report_d;
  logic        unknown;
  logic [7:0]  seq;
  logic [15:0] pgn;
  logic [63:0] p;
  op_e         op;

  assign op  = op_e'(item_i.op);
  assign pgn = item_i.ext_id[23:8];
  assign p   = item_i.payload;

  always_comb begin
    for (int i = 0; i < NumAge; i++) begin
      age_lim[i] = (i >= AGE_DIST) ? slow_to_q : fast_to_q;
      age_inc[i] = age_q[i] + 8'd1;
      expired[i] = (age_inc[i] == age_lim[i]);
    end
  end

  always_comb begin
    spd_valid_d = spd_valid_q;
    tach_d      = tach_q;
    wheel_d     = wheel_q;
    dir_d       = dir_q;
    rpm_d       = rpm_q;
    brake_d     = brake_q;
    accel_d     = accel_q;
    dist_d      = dist_q;
    fuel_d      = fuel_q;
    age_d       = age_q;
    report_d    = report_q;
    unknown     = 1'b0;
    seq         = 8'd0;
    unique case (op)
      OP_FRAME: begin
        unique case (pgn)
          PGN_TACH: begin
            spd_valid_d[0] = 1'b1;
            tach_d         = p[63:56];
            dir_d          = {6'd0, p[31:30]};
            age_d[AGE_TACH] = 8'd0;
          end
          PGN_WHEEL: begin
            spd_valid_d[1]   = 1'b1;
            wheel_d          = p[23:16];
            age_d[AGE_WHEEL] = 8'd0;
          end
          PGN_IGNORED: ;
          PGN_BRAKE: begin
            brake_d          = p[15:8];
            age_d[AGE_BRAKE] = 8'd0;
          end
          PGN_ACCEL: begin
            accel_d          = p[15:8];
            age_d[AGE_ACCEL] = 8'd0;
          end
          PGN_RPM: begin
            rpm_d          = p[39:24];
            age_d[AGE_RPM] = 8'd0;
          end
          PGN_DIST: begin
            dist_d[0]       = p[63:32];
            dist_d[1]       = p[31:0];
            age_d[AGE_DIST] = 8'd0;
          end
          PGN_FUEL: begin
            fuel_d[0]       = {2'b00, p[31:2]};
            fuel_d[1]       = {2'b00, p[63:34]};
            age_d[AGE_FUEL] = 8'd0;
          end
          default: unknown = 1'b1;
        endcase
      end
      OP_TICK: begin
        for (int i = 0; i < NumAge; i++) begin
          age_d[i] = expired[i] ? 8'd0 : age_inc[i];
        end
        if (expired[AGE_TACH]) begin
          spd_valid_d[0] = 1'b0;
          dir_d          = 8'hFF;
        end
        if (expired[AGE_WHEEL]) spd_valid_d[1] = 1'b0;
        if (expired[AGE_RPM])   rpm_d   = STALE_16;
        if (expired[AGE_BRAKE]) brake_d = 8'hFF;
        if (expired[AGE_ACCEL]) accel_d = 8'hFF;
        if (expired[AGE_DIST]) begin
          dist_d[0] = STALE_32;
          dist_d[1] = STALE_32;
        end
        if (expired[AGE_FUEL]) begin
          fuel_d[0] = STALE_32;
          fuel_d[1] = STALE_32;
        end
      end
      OP_REPORT: begin
        seq      = report_q;
        report_d = report_q + 8'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    snap_o.unknown_pgn    = unknown;
    snap_o.speed          = (spd_valid_d == 2'b01) ? tach_d :
                            (spd_valid_d == 2'b10) ? wheel_d : 8'hFF;
    snap_o.direction      = dir_d;
    snap_o.rpm            = rpm_d;
    snap_o.brake          = brake_d;
    snap_o.accel          = accel_d;
    snap_o.trip_distance  = dist_d[0];
    snap_o.total_distance = dist_d[1];
    snap_o.trip_fuel      = fuel_d[0];
    snap_o.total_fuel     = fuel_d[1];
    snap_o.sequence_res   = seq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_to_q <= FAST_TIMEOUT_RST;
      slow_to_q <= SLOW_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FAST_TIMEOUT: fast_to_q <= cfg_wdata_i;
        REG_SLOW_TIMEOUT: slow_to_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_valid_q <= 2'b00;
      tach_q      <= 8'hFF;
      wheel_q     <= 8'hFF;
      dir_q       <= 8'hFF;
      rpm_q       <= STALE_16;
      brake_q     <= 8'hFF;
      accel_q     <= 8'hFF;
      dist_q      <= '{STALE_32, STALE_32};
      fuel_q      <= '{STALE_32, STALE_32};
      age_q       <= '{default: 8'd0};
      report_q    <= 8'd0;
    end else if (adv_i) begin
      spd_valid_q <= spd_valid_d;
      tach_q      <= tach_d;
      wheel_q     <= wheel_d;
      dir_q       <= dir_d;
      rpm_q       <= rpm_d;
      brake_q     <= brake_d;
      accel_q     <= accel_d;
      dist_q      <= dist_d;
      fuel_q      <= fuel_d;
      age_q       <= age_d;
      report_q    <= report_d;
    end
  end

  a_report_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (op == OP_REPORT) |=> report_q == 8'($past(report_q) + 8'd1))
    else $error("report count did not advance");

  a_report_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv_i && (op == OP_REPORT)) |=> $stable(report_q))
    else $error("report count moved without a report");

  a_unknown_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && snap_o.unknown_pgn |-> op == OP_FRAME)
    else $error("unknown group flagged outside a frame");

  a_speed_ambiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (spd_valid_d == 2'b11) |-> snap_o.speed == 8'hFF)
    else $error("speed not blanked with both sources valid");

endmodule

### rtl/cpsd_out_stage.sv
`timescale 1ns / 1ps
module cpsd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                snap_valid_i,
  input  cpsd_pkg::out_item_t snap_i,
  output logic                snap_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpsd_pkg::out_item_t out_data_o
);
  import cpsd_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  assign snap_ready_o = !valid_q || !out_stall_i;
  assign out_valid_o  = valid_q;
  assign out_data_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i && snap_ready_o) begin
      data_q <= snap_i;
    end
  end

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |=> valid_q && $stable(data_q))
    else $error("stalled result lost");

endmodule

### rtl/can_pgn_signal_decoder_with_timeouts_core.sv
`timescale 1ns / 1ps
// Vehicle-signal decoder for received extended-ID CAN frames. Each input
// transfer is a frame (op 0), a 10 ms tick (op 1), a report request (op 2)
// or a no-op (op 3) and yields exactly one result transfer: a snapshot of all
// held signals after that item's update. An item is accepted into the input
// register; its decode and state update then load the result register once
// the result side can take it, and the result transfers from there. The block
// takes one item every cycle while the result side does not stall; a stalled
// result holds the input register, which then stalls the input. The user must
// write timeouts through the configuration port only while the block is idle;
// the block itself does not enforce this.
module can_pgn_signal_decoder_with_timeouts_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpsd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpsd_pkg::out_item_t out_data_o
);
  import cpsd_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      snap_ready;
  logic      adv;
  out_item_t snap;

  assign adv = item_valid && snap_ready;

  cpsd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (snap_ready)
  );

  cpsd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .adv_i        (adv),
    .snap_o       (snap)
  );

  cpsd_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (item_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cpsd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  can_pgn_signal_decoder_with_timeouts_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Signal image held by the testbench
  logic [7:0]  fast_limit;
  logic [7:0]  slow_limit;
  logic [1:0]  speed_src_valid;
  logic [7:0]  tach_kph;
  logic [7:0]  wheel_kph;
  logic [7:0]  dir_held;
  logic [15:0] rpm_held;
  logic [7:0]  brake_held;
  logic [7:0]  accel_held;
  logic [31:0] dist_held [2];
  logic [31:0] fuel_held [2];
  logic [7:0]  age_cnt [NumAge];
  logic [7:0]  report_cnt;

  out_item_t   snapshot_q [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  logic [15:0] known_pgns [7] = '{PGN_TACH, PGN_WHEEL, PGN_RPM, PGN_BRAKE, PGN_ACCEL,
                                  PGN_DIST, PGN_FUEL};

  task automatic clear_signal_image();
    fast_limit      = FAST_TIMEOUT_RST;
    slow_limit      = SLOW_TIMEOUT_RST;
    speed_src_valid = 2'b00;
    tach_kph        = 8'hFF;
    wheel_kph       = 8'hFF;
    dir_held        = 8'hFF;
    rpm_held        = STALE_16;
    brake_held      = 8'hFF;
    accel_held      = 8'hFF;
    for (int i = 0; i < 2; i++) begin
      dist_held[i] = STALE_32;
      fuel_held[i] = STALE_32;
    end
    for (int i = 0; i < NumAge; i++) age_cnt[i] = 8'd0;
    report_cnt = 8'd0;
  endtask

  // Advance one age counter; report whether it just reached its limit
  function automatic bit age_expires(input int unsigned slot, input logic [7:0] lim);
    age_cnt[slot] = age_cnt[slot] + 8'd1;
    if (age_cnt[slot] == lim) begin
      age_cnt[slot] = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Update the signal image for one accepted transfer and queue its snapshot
  task automatic decode_snapshot(input in_item_t item);
    out_item_t   snap;
    logic [15:0] group;
    logic [63:0] p;
    snap  = '0;
    group = item.ext_id[23:8];
    p     = item.payload;
    case (item.op)
      OP_FRAME: begin
        case (group)
          PGN_TACH: begin
            speed_src_valid[0] = 1'b1;
            tach_kph           = p[63:56];
            dir_held           = {6'd0, p[31:30]};
            age_cnt[AGE_TACH]  = 8'd0;
          end
          PGN_WHEEL: begin
            speed_src_valid[1] = 1'b1;
            wheel_kph          = p[23:16];
            age_cnt[AGE_WHEEL] = 8'd0;
          end
          PGN_IGNORED: ;
          PGN_BRAKE: begin
            brake_held         = p[15:8];
            age_cnt[AGE_BRAKE] = 8'd0;
          end
          PGN_ACCEL: begin
            accel_held         = p[15:8];
            age_cnt[AGE_ACCEL] = 8'd0;
          end
          PGN_RPM: begin
            rpm_held         = {p[39:32], p[31:24]};
            age_cnt[AGE_RPM] = 8'd0;
          end
          PGN_DIST: begin
            dist_held[0]      = p[63:32];
            dist_held[1]      = p[31:0];
            age_cnt[AGE_DIST] = 8'd0;
          end
          PGN_FUEL: begin
            fuel_held[0]      = p[31:0] >> 2;
            fuel_held[1]      = p[63:32] >> 2;
            age_cnt[AGE_FUEL] = 8'd0;
          end
          default: snap.unknown_pgn = 1'b1;
        endcase
      end
      OP_TICK: begin
        if (age_expires(AGE_TACH, fast_limit)) begin
          speed_src_valid[0] = 1'b0;
          dir_held           = 8'hFF;
        end
        if (age_expires(AGE_WHEEL, fast_limit)) speed_src_valid[1] = 1'b0;
        if (age_expires(AGE_RPM, fast_limit)) rpm_held = STALE_16;
        if (age_expires(AGE_BRAKE, fast_limit)) brake_held = 8'hFF;
        if (age_expires(AGE_ACCEL, fast_limit)) accel_held = 8'hFF;
        if (age_expires(AGE_DIST, slow_limit)) begin
          dist_held[0] = STALE_32;
          dist_held[1] = STALE_32;
        end
        if (age_expires(AGE_FUEL, slow_limit)) begin
          fuel_held[0] = STALE_32;
          fuel_held[1] = STALE_32;
        end
      end
      OP_REPORT: begin
        snap.sequence_res = report_cnt;
        report_cnt        = report_cnt + 8'd1;
      end
      default: ;
    endcase
    case (speed_src_valid)
      2'b01:   snap.speed = tach_kph;
      2'b10:   snap.speed = wheel_kph;
      default: snap.speed = 8'hFF;
    endcase
    snap.direction      = dir_held;
    snap.rpm            = rpm_held;
    snap.brake          = brake_held;
    snap.accel          = accel_held;
    snap.trip_distance  = dist_held[0];
    snap.total_distance = dist_held[1];
    snap.trip_fuel      = fuel_held[0];
    snap.total_fuel     = fuel_held[1];
    snapshot_q.push_back(snap);
  endtask

  // Called at a falling edge; returns at a falling edge
  task automatic send_item(input in_item_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_snapshot(item);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // Hold input until every snapshot is back and the pipeline is empty
  task automatic drain_block();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (snapshot_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_timeouts(input logic [7:0] fast, input logic [7:0] slow);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FAST_TIMEOUT;
    cfg_wdata_i <= fast;
    @(negedge clk_i);
    cfg_idx_i   <= REG_SLOW_TIMEOUT;
    cfg_wdata_i <= slow;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    fast_limit = fast;
    slow_limit = slow;
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_frame(input logic [15:0] pgn, input logic [63:0] p);
    in_item_t item;
    item.op      = OP_FRAME;
    item.ext_id  = {5'($urandom), pgn, 8'($urandom)};
    item.payload = p;
    return item;
  endfunction

  function automatic in_item_t make_op(input op_e op);
    in_item_t item;
    item.op      = op;
    item.ext_id  = 29'($urandom);
    item.payload = {$urandom, $urandom};
    return item;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)
      item = make_frame(known_pgns[$urandom_range(0, 6)], {$urandom, $urandom});
    else if (r < 55)
      item = make_frame(PGN_IGNORED, {$urandom, $urandom});
    else if (r < 62) begin
      item = make_op(OP_FRAME);
    end else if (r < 88)
      item = make_op(OP_TICK);
    else if (r < 97)
      item = make_op(OP_REPORT);
    else
      item = make_op(OP_NONE);
    return item;
  endfunction

  task automatic test_reset_and_groups();
    in_item_t item;
    send_item(make_op(OP_REPORT));
    send_item(make_op(OP_NONE));
    foreach (known_pgns[i]) send_item(make_frame(known_pgns[i], '1));
    send_item(make_op(OP_REPORT));
    send_item(make_frame(PGN_TACH, '0));
    send_item(make_frame(PGN_WHEEL, '0));
    send_item(make_frame(PGN_RPM, '0));
    item = '{op: OP_FRAME, ext_id: {5'h1F, PGN_IGNORED, 8'hFF}, payload: '1};
    send_item(item);
    // unhandled groups at both ends of the identifier range
    item = '{op: OP_FRAME, ext_id: '1, payload: '1};
    send_item(item);
    item = '{op: OP_FRAME, ext_id: '0, payload: '0};
    send_item(item);
    item = '{op: OP_NONE, ext_id: '1, payload: '1};
    send_item(item);
    send_item(make_op(OP_REPORT));
  endtask

  task automatic test_timeouts();
    // a fast limit of 1 and a slow limit of 255: tach goes stale on the first tick
    write_timeouts(8'd1, 8'd255);
    send_item(make_frame(PGN_TACH, {$urandom, $urandom}));
    send_item(make_op(OP_TICK));
    send_item(make_frame(PGN_WHEEL, {$urandom, $urandom}));
    send_item(make_op(OP_REPORT));
    send_item(make_op(OP_TICK));
    write_timeouts(8'd2, 8'd3);
    send_item(make_frame(PGN_TACH, {$urandom, $urandom}));
    send_item(make_op(OP_TICK));
    send_item(make_frame(PGN_WHEEL, {$urandom, $urandom}));
    send_item(make_frame(PGN_DIST, {$urandom, $urandom}));
    send_item(make_frame(PGN_FUEL, {$urandom, $urandom}));
    repeat (4) send_item(make_op(OP_TICK));
  endtask

  task automatic test_counter_wrap();
    // a zero limit is only reached after the counter wraps
    write_timeouts(8'd0, 8'd0);
    foreach (known_pgns[i]) send_item(make_frame(known_pgns[i], {$urandom, $urandom}));
    repeat (257) send_item(make_op(OP_TICK));
    write_timeouts(8'd255, 8'd1);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    write_timeouts(8'($urandom_range(1, 12)), 8'($urandom_range(1, 30)));
    for (int unsigned i = 0; i < count; i++) begin
      send_item(random_item());
      if ($urandom_range(0, 59) == 0) drain_block();
    end
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (snapshot_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none actual %h",
                 $time, out_data_o);
        mismatches++;
      end else begin
        want = snapshot_q.pop_front();
        compare_field("unknown_pgn", 32'(want.unknown_pgn), 32'(out_data_o.unknown_pgn));
        compare_field("speed", 32'(want.speed), 32'(out_data_o.speed));
        compare_field("direction", 32'(want.direction), 32'(out_data_o.direction));
        compare_field("rpm", 32'(want.rpm), 32'(out_data_o.rpm));
        compare_field("brake", 32'(want.brake), 32'(out_data_o.brake));
        compare_field("accel", 32'(want.accel), 32'(out_data_o.accel));
        compare_field("trip_distance", want.trip_distance, out_data_o.trip_distance);
        compare_field("total_distance", want.total_distance, out_data_o.total_distance);
        compare_field("trip_fuel", want.trip_fuel, out_data_o.trip_fuel);
        compare_field("total_fuel", want.total_fuel, out_data_o.total_fuel);
        compare_field("sequence_res", 32'(want.sequence_res),
                      32'(out_data_o.sequence_res));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_FAST_TIMEOUT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    clear_signal_image();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 14;
    recv_stall_pct = 55;
    test_reset_and_groups();
    test_timeouts();
    test_random_traffic(37);

    send_idle_pct  = 55;
    recv_stall_pct = 14;
    test_counter_wrap();
    test_random_traffic(37);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(37);

    drain_block();
    if (mismatches == 0)
      $display("can_pgn_signal_decoder_with_timeouts_core verification clean");
    else
      $display("can_pgn_signal_decoder_with_timeouts_core verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("can_pgn_signal_decoder_with_timeouts_core verification failed");
    $finish;
  end

endmodule

### files.f
rtl/cpsd_pkg.sv
rtl/cpsd_in_stage.sv
rtl/cpsd_decode.sv
rtl/cpsd_out_stage.sv
rtl/can_pgn_signal_decoder_with_timeouts_core.sv
test/testbench.sv
